// ===== rtl/iace_pkg.sv =====
// iace_pkg: types, character codes and decode for the infix evaluator.
// No dependencies; used by iace_muldiv, the evaluator top level and the testbench.
package iace_pkg;

	localparam logic [7:0] CH_ADD = 8'h2B;
	localparam logic [7:0] CH_SUB = 8'h2D;
	localparam logic [7:0] CH_MUL = 8'h2A;
	localparam logic [7:0] CH_DIV = 8'h2F;
	localparam logic [7:0] CH_MOD = 8'h25;
	localparam logic [7:0] CH_END = 8'h00;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam int unsigned RES_WIDTH = 32;

	typedef enum logic [1:0] {
		HI_NONE,
		HI_MUL,
		HI_DIV,
		HI_MOD
	} high_op_t;

	typedef enum logic [1:0] {
		LO_NONE,
		LO_ADD,
		LO_SUB
	} low_op_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_DIGIT,
		ACT_MUL,
		ACT_DIV,
		ACT_MOD,
		ACT_ADD,
		ACT_SUB,
		ACT_END
	} act_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TERM,
		S_SUM,
		S_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_FIN
	} md_state_t;

	typedef struct packed {
		logic     start;
		high_op_t op;
	} md_req_t;

	typedef struct packed {
		logic done;
		logic dz;
	} md_rsp_t;

	function automatic act_t decode_char(input logic [7:0] c);
		act_t a;
		a = ACT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			a = ACT_DIGIT;
		end else begin
			unique case (c)
				CH_ADD:  a = ACT_ADD;
				CH_SUB:  a = ACT_SUB;
				CH_MUL:  a = ACT_MUL;
				CH_DIV:  a = ACT_DIV;
				CH_MOD:  a = ACT_MOD;
				CH_END:  a = ACT_END;
				default: a = ACT_NONE;
			endcase
		end
		return a;
	endfunction

endpackage

// ===== rtl/iace_char_if.sv =====
// iace_char_if: valid/ready channel carrying one expression character.
// No dependencies.
interface iace_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/iace_res_if.sv =====
// iace_res_if: valid/ready channel carrying one evaluation result.
// No dependencies.
interface iace_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               div_zero;

	modport source (output valid, output value, output div_zero, input ready);
	modport sink (input valid, input value, input div_zero, output ready);
endinterface

// ===== rtl/iace_muldiv.sv =====
// iace_muldiv: shared iterative unit, shift-add multiply and restoring
// signed divide/modulo, one bit per cycle over one adder. Uses iace_pkg.
module iace_muldiv #(
	parameter int W = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  iace_pkg::md_req_t req,
	input  logic [W-1:0]    a,
	input  logic [W-1:0]    b,
	output iace_pkg::md_rsp_t rsp,
	output logic [W-1:0]    res
);

	localparam int CW = $clog2(W);

	iace_pkg::md_state_t st_q, st_d;
	iace_pkg::high_op_t  op_q;
	logic [CW-1:0]       cnt_q;
	logic [W-1:0]        x_q, y_q, acc_q;
	logic                qneg_q, rneg_q, zf_q;

	logic                is_mul;
	logic [W-1:0]        opa, opb;
	logic [W:0]          sum;
	logic [W-1:0]        mag_a, mag_b;

	assign is_mul = (op_q == iace_pkg::HI_MUL);
	assign mag_a  = a[W-1] ? (~a + W'(1)) : a;
	assign mag_b  = b[W-1] ? (~b + W'(1)) : b;

	// single shared adder: accumulate for multiply, trial subtract for divide
	always_comb begin
		opa = is_mul ? acc_q : {acc_q[W-2:0], x_q[W-1]};
		opb = is_mul ? (y_q[0] ? x_q : '0) : ~y_q;
		sum = {1'b0, opa} + {1'b0, opb} + (W+1)'(!is_mul);
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			iace_pkg::MD_IDLE: begin
				if (req.start) begin
					if (req.op != iace_pkg::HI_MUL && b == '0)
						st_d = iace_pkg::MD_FIN;
					else
						st_d = iace_pkg::MD_RUN;
				end
			end
			iace_pkg::MD_RUN: begin
				if (cnt_q == '0)
					st_d = iace_pkg::MD_FIN;
			end
			iace_pkg::MD_FIN: st_d = iace_pkg::MD_IDLE;
			default: st_d = iace_pkg::MD_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (st_q == iace_pkg::MD_FIN);
		rsp.dz   = zf_q;
		res      = '0;
		if (!zf_q) begin
			case (op_q)
				iace_pkg::HI_DIV: res = qneg_q ? (~x_q + W'(1)) : x_q;
				iace_pkg::HI_MOD: res = rneg_q ? (~acc_q + W'(1)) : acc_q;
				default:          res = acc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= iace_pkg::MD_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == iace_pkg::MD_IDLE && req.start) begin
			op_q   <= req.op;
			cnt_q  <= CW'(W-1);
			acc_q  <= '0;
			qneg_q <= a[W-1] ^ b[W-1];
			rneg_q <= a[W-1];
			zf_q   <= (req.op != iace_pkg::HI_MUL) && (b == '0);
			if (req.op == iace_pkg::HI_MUL) begin
				x_q <= a;
				y_q <= b;
			end else begin
				x_q <= mag_a;
				y_q <= mag_b;
			end
		end else if (st_q == iace_pkg::MD_RUN) begin
			cnt_q <= cnt_q - CW'(1);
			if (is_mul) begin
				acc_q <= sum[W-1:0];
				x_q   <= {x_q[W-2:0], 1'b0};
				y_q   <= {1'b0, y_q[W-1:1]};
			end else if (sum[W]) begin
				acc_q <= sum[W-1:0];
				x_q   <= {x_q[W-2:0], 1'b1};
			end else begin
				acc_q <= opa;
				x_q   <= {x_q[W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== rtl/infix_arith_char_evaluator_top.sv =====
// Infix evaluator top level: character sequencer, accumulators, output register.
// Depends on iace_pkg, iace_char_if, iace_res_if and iace_muldiv.
//
// Characters arrive one per transfer; digits build an unsigned number, + - * / %
// combine with * / % binding tighter, and a zero byte yields one result. A digit
// or ignored character is taken in the idle state. With a * / % pending, an
// operator waits for the shared shift-add/restoring unit, which runs one bit per
// cycle; a zero divisor is caught at the start. A + or - then passes through the
// sum state; the terminator passes through the sum and emit states. The result
// sits in an output register so the next expression may start while it waits.
module infix_arith_char_evaluator_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	iace_char_if.sink   char_in,
	iace_res_if.source  res_out
);

	localparam int W  = VALUE_WIDTH;
	localparam int XW = (W > 32) ? W : 32;

	iace_pkg::seq_state_t st_q, st_d;
	iace_pkg::act_t       act, act_q;
	iace_pkg::high_op_t   high_q;
	iace_pkg::low_op_t    low_q;
	logic [W-1:0]         sum_q, term_q, cur_q;
	logic                 err_q;

	logic                 out_valid_q;
	logic [31:0]          out_value_q;
	logic                 out_dz_q;

	iace_pkg::md_req_t    md_req;
	iace_pkg::md_rsp_t    md_rsp;
	logic [W-1:0]         md_res;

	logic                 accept, is_op, emit;
	logic [W-1:0]         cur_next, sum_next;
	logic signed [XW-1:0] sum_ext;

	iace_muldiv #(.W(W)) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (term_q),
		.b      (cur_q),
		.rsp    (md_rsp),
		.res    (md_res)
	);

	assign act      = iace_pkg::decode_char(char_in.char_code);
	assign accept   = char_in.valid && char_in.ready;
	assign is_op    = (act != iace_pkg::ACT_NONE) && (act != iace_pkg::ACT_DIGIT);
	assign cur_next = (cur_q << 3) + (cur_q << 1) + {{(W-4){1'b0}}, char_in.char_code[3:0]};
	assign sum_ext  = XW'(signed'(sum_q));

	always_comb begin
		case (low_q)
			iace_pkg::LO_ADD: sum_next = sum_q + term_q;
			iace_pkg::LO_SUB: sum_next = sum_q - term_q;
			default:          sum_next = term_q;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			iace_pkg::S_IDLE: begin
				if (accept && is_op) begin
					if (high_q != iace_pkg::HI_NONE)
						st_d = iace_pkg::S_TERM;
					else if (act inside {iace_pkg::ACT_ADD, iace_pkg::ACT_SUB,
							iace_pkg::ACT_END})
						st_d = iace_pkg::S_SUM;
				end
			end
			iace_pkg::S_TERM: begin
				if (md_rsp.done) begin
					if (act_q inside {iace_pkg::ACT_ADD, iace_pkg::ACT_SUB,
							iace_pkg::ACT_END})
						st_d = iace_pkg::S_SUM;
					else
						st_d = iace_pkg::S_IDLE;
				end
			end
			iace_pkg::S_SUM: begin
				st_d = (act_q == iace_pkg::ACT_END) ? iace_pkg::S_EMIT : iace_pkg::S_IDLE;
			end
			iace_pkg::S_EMIT: begin
				if (emit)
					st_d = iace_pkg::S_IDLE;
			end
			default: st_d = iace_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		char_in.ready = (st_q == iace_pkg::S_IDLE);
		md_req.start  = accept && is_op && (high_q != iace_pkg::HI_NONE);
		md_req.op     = high_q;
		emit          = (st_q == iace_pkg::S_EMIT) && (!out_valid_q || res_out.ready);
	end

	assign res_out.valid    = out_valid_q;
	assign res_out.value    = out_value_q;
	assign res_out.div_zero = out_dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= iace_pkg::S_IDLE;
			act_q       <= iace_pkg::ACT_NONE;
			high_q      <= iace_pkg::HI_NONE;
			low_q       <= iace_pkg::LO_NONE;
			sum_q       <= '0;
			term_q      <= '0;
			cur_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid_q && res_out.ready && !emit)
				out_valid_q <= 1'b0;

			unique case (st_q)
				iace_pkg::S_IDLE: begin
					if (accept && act == iace_pkg::ACT_DIGIT) begin
						cur_q <= cur_next;
					end else if (accept && is_op) begin
						act_q <= act;
						if (high_q == iace_pkg::HI_NONE) begin
							term_q <= cur_q;
							cur_q  <= '0;
							case (act)
								iace_pkg::ACT_MUL: high_q <= iace_pkg::HI_MUL;
								iace_pkg::ACT_DIV: high_q <= iace_pkg::HI_DIV;
								iace_pkg::ACT_MOD: high_q <= iace_pkg::HI_MOD;
								default:           high_q <= iace_pkg::HI_NONE;
							endcase
						end
					end
				end
				iace_pkg::S_TERM: begin
					if (md_rsp.done) begin
						term_q <= md_res;
						cur_q  <= '0;
						err_q  <= err_q | md_rsp.dz;
						case (act_q)
							iace_pkg::ACT_MUL: high_q <= iace_pkg::HI_MUL;
							iace_pkg::ACT_DIV: high_q <= iace_pkg::HI_DIV;
							iace_pkg::ACT_MOD: high_q <= iace_pkg::HI_MOD;
							default:           high_q <= iace_pkg::HI_NONE;
						endcase
					end
				end
				iace_pkg::S_SUM: begin
					sum_q  <= sum_next;
					term_q <= '0;
					case (act_q)
						iace_pkg::ACT_ADD: low_q <= iace_pkg::LO_ADD;
						iace_pkg::ACT_SUB: low_q <= iace_pkg::LO_SUB;
						default:           low_q <= iace_pkg::LO_NONE;
					endcase
				end
				iace_pkg::S_EMIT: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						sum_q       <= '0;
						term_q      <= '0;
						cur_q       <= '0;
						high_q      <= iace_pkg::HI_NONE;
						low_q       <= iace_pkg::LO_NONE;
						err_q       <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= err_q ? '0 : sum_ext[31:0];
			out_dz_q    <= err_q;
		end
	end

`ifndef SYNTHESIS
	a_done_in_term: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (st_q == iace_pkg::S_TERM))
		else $error("muldiv finished outside term state");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |-> (st_q == iace_pkg::S_IDLE))
		else $error("muldiv started while sequencer busy");
	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(st_q) == iace_pkg::S_EMIT))
		else $error("result loaded outside emit state");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.div_zero) |-> (res_out.value == '0))
		else $error("division by zero result not cleared");
`endif

endmodule

// ===== test/infix_arith_char_evaluator_top_test.sv =====
// Testbench for infix_arith_char_evaluator_top: streams expression characters and checks results
// against an in-bench evaluator. Depends on iace_pkg, iace_char_if, iace_res_if and the RTL.
`timescale 1ns / 100ps

module infix_arith_char_evaluator_top_test;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned LONG_HOLD = 300;

	typedef struct {
		logic signed [31:0] value;
		logic               div_zero;
	} eval_result_t;

	logic clk;
	logic arst_n;

	iace_char_if char_if ();
	iace_res_if  res_if ();

	infix_arith_char_evaluator_top #(
		.VALUE_WIDTH(32)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.char_in(char_if.sink),
		.res_out(res_if.source)
	);

	// evaluator state
	logic [31:0]        sum_acc;
	logic [31:0]        term_acc;
	logic [31:0]        cur_num;
	iace_pkg::low_op_t  low_pend;
	iace_pkg::high_op_t high_pend;
	logic               dz_seen;

	eval_result_t expected_results[$];

	int unsigned chars_sent;
	int unsigned results_checked;
	int unsigned dz_results;
	int unsigned errors;
	int unsigned hold_len;
	int unsigned long_holds;
	bit          quiet;

	logic [7:0] op_chars[5] = '{iace_pkg::CH_ADD, iace_pkg::CH_SUB, iace_pkg::CH_MUL,
		iace_pkg::CH_DIV, iace_pkg::CH_MOD};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] trunc_divide(input logic [31:0] a, input logic [31:0] b,
			input logic want_rem);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		logic [31:0] r;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (a[31] != b[31])
			q = -q;
		if (a[31])
			r = -r;
		return want_rem ? r : q;
	endfunction

	task automatic clear_evaluator();
		sum_acc = '0;
		term_acc = '0;
		cur_num = '0;
		low_pend = iace_pkg::LO_NONE;
		high_pend = iace_pkg::HI_NONE;
		dz_seen = 1'b0;
	endtask

	// advance the evaluator by one accepted character
	task automatic evaluate_char(input logic [7:0] c);
		eval_result_t r;
		if (c >= iace_pkg::CH_ZERO && c <= iace_pkg::CH_NINE) begin
			cur_num = cur_num * 32'd10 + 32'(c - iace_pkg::CH_ZERO);
			return;
		end
		if (!(c inside {iace_pkg::CH_ADD, iace_pkg::CH_SUB, iace_pkg::CH_MUL,
				iace_pkg::CH_DIV, iace_pkg::CH_MOD, iace_pkg::CH_END}))
			return;
		case (high_pend)
			iace_pkg::HI_MUL: term_acc = term_acc * cur_num;
			iace_pkg::HI_DIV, iace_pkg::HI_MOD: begin
				if (cur_num == '0) begin
					term_acc = '0;
					dz_seen = 1'b1;
				end else begin
					term_acc = trunc_divide(term_acc, cur_num,
						high_pend == iace_pkg::HI_MOD);
				end
			end
			default: term_acc = cur_num;
		endcase
		high_pend = iace_pkg::HI_NONE;
		cur_num = '0;
		case (c)
			iace_pkg::CH_MUL: high_pend = iace_pkg::HI_MUL;
			iace_pkg::CH_DIV: high_pend = iace_pkg::HI_DIV;
			iace_pkg::CH_MOD: high_pend = iace_pkg::HI_MOD;
			default: begin
				case (low_pend)
					iace_pkg::LO_ADD: sum_acc = sum_acc + term_acc;
					iace_pkg::LO_SUB: sum_acc = sum_acc - term_acc;
					default: sum_acc = term_acc;
				endcase
				low_pend = iace_pkg::LO_NONE;
				term_acc = '0;
				if (c == iace_pkg::CH_ADD) begin
					low_pend = iace_pkg::LO_ADD;
				end else if (c == iace_pkg::CH_SUB) begin
					low_pend = iace_pkg::LO_SUB;
				end else begin
					r.value = dz_seen ? '0 : sum_acc;
					r.div_zero = dz_seen;
					expected_results.push_back(r);
					clear_evaluator();
				end
			end
		endcase
	endtask

	task automatic report_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// one character transfer; the model advances on acceptance
	task automatic send_char(input logic [7:0] c);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 18);
			char_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_if.valid <= 1'b1;
		char_if.char_code <= c;
		@(posedge clk);
		while (!char_if.ready) @(posedge clk);
		evaluate_char(c);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_number();
		logic [31:0] num;
		logic [63:0] wide;
		case ($urandom_range(0, 11))
			0: num = '0;
			1: num = 32'h8000_0000;
			2: num = 32'hFFFF_FFFF;
			3: num = $urandom();
			4: begin
				wide = {$urandom(), $urandom()};
				send_text($sformatf("%0d", wide));
				return;
			end
			5, 6, 7: num = $urandom_range(0, 9);
			default: num = $urandom_range(0, 999);
		endcase
		send_text($sformatf("%0d", num));
	endtask

	// terminated expression with random content, occasional spaces, a leading operator and missing operands
	task automatic send_expression(input int unsigned max_terms);
		int unsigned terms;
		terms = $urandom_range(1, max_terms);
		if ($urandom_range(0, 7) == 0)
			send_char(op_chars[$urandom_range(0, 4)]);
		for (int unsigned t = 0; t < terms; t++) begin
			if (t != 0)
				send_char(op_chars[$urandom_range(0, 4)]);
			if ($urandom_range(0, 5) == 0)
				send_char(8'h20);
			if ($urandom_range(0, 11) != 0)
				send_number();
		end
		send_char(iace_pkg::CH_END);
	endtask

	// receiver: random stalls, or one long hold when asked
	initial begin
		int unsigned gap;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				res_if.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				long_holds++;
				res_if.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 18);
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		eval_result_t exp_r;
		if (arst_n && res_if.valid && res_if.ready) begin
			results_checked++;
			if (res_if.div_zero)
				dz_results++;
			if (expected_results.size() == 0) begin
				report_error($sformatf("result value=%0d div_zero=%0b with none expected",
					res_if.value, res_if.div_zero));
			end else begin
				exp_r = expected_results.pop_front();
				if (res_if.value !== exp_r.value || res_if.div_zero !== exp_r.div_zero)
					report_error($sformatf("expected value=%0d div_zero=%0b, got value=%0d div_zero=%0b",
						exp_r.value, exp_r.div_zero, res_if.value, res_if.div_zero));
			end
		end
	end

	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((char_if.valid && char_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("infix_arith_char_evaluator_top_test: done, errors");
		$finish;
	end

	// all operators, empty expression, division by zero, missing operand, ignored bytes
	task automatic test_directed();
		send_char(iace_pkg::CH_END);
		send_text("7+3*2-9/4%3");
		send_char(iace_pkg::CH_END);
		send_text("5/0");
		send_char(iace_pkg::CH_END);
		send_text("-8 x");
		send_char(8'hFF);
		send_char(8'h80);
		send_char(iace_pkg::CH_END);
	endtask

	task automatic test_random_expressions(input int unsigned n_chars);
		int unsigned stop_at;
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at)
			send_expression(6);
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_output_backpressure();
		hold_len = LONG_HOLD;
		repeat (12) send_expression(2);
	endtask

	// random bytes and broken sequences
	task automatic test_noise(input int unsigned n_chars);
		int unsigned stop_at;
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			case ($urandom_range(0, 5))
				0: send_char(iace_pkg::CH_END);
				1, 2: send_char(8'($urandom_range(0, 255)));
				3: send_char(op_chars[$urandom_range(0, 4)]);
				default: send_number();
			endcase
		end
		send_char(iace_pkg::CH_END);
	endtask

	initial begin
		char_if.valid = 1'b0;
		char_if.char_code = '0;
		arst_n = 1'b0;
		chars_sent = 0;
		results_checked = 0;
		dz_results = 0;
		errors = 0;
		hold_len = 0;
		long_holds = 0;
		quiet = 1'b0;
		clear_evaluator();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_expressions(600);
		test_output_backpressure();
		test_noise(250);
		quiet = 1'b1;
		test_random_expressions(300);

		char_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_results.size()));

		$display("covered %0d characters: all operators, wrap, div/mod by zero, noise bytes",
			chars_sent);
		$display("checked %0d results (%0d with div_zero), %0d long output holds, %0d errors",
			results_checked, dz_results, long_holds, errors);
		if (errors == 0) begin
			$display("infix_arith_char_evaluator_top_test: done, clean");
		end else begin
			$display("infix_arith_char_evaluator_top_test: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/iace_pkg.sv
rtl/iace_char_if.sv
rtl/iace_res_if.sv
rtl/iace_muldiv.sv
rtl/infix_arith_char_evaluator_top.sv
test/infix_arith_char_evaluator_top_test.sv
